### hdl/qat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and constants of the quoted argument tokenizer: character
// codes, scan modes, status codes, register map and the structs passed
// between the tokenizer modules.
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
    localparam logic [CHAR_W-1:0] CH_LOW_N  = 8'h6e;
    localparam logic [CHAR_W-1:0] CH_LOW_R  = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LOW_T  = 8'h74;

    localparam logic [COUNT_W-1:0] MAX_ARGS_RESET = 7'd16;

    // register index, taken from the word address bit
    localparam logic REG_MAX_ARGS = 1'b0;

    typedef enum logic [1:0] {
        MODE_GAP   = 2'd0,
        MODE_TOKEN = 2'd1,
        MODE_QUOTE = 2'd2
    } scan_mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 2'd0,
        ST_TOO_MANY     = 2'd1,
        ST_UNTERMINATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_line;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic               char_valid;
        logic               token_start;
        logic               token_end;
        logic               line_done;
        status_t            status;
        logic [COUNT_W-1:0] arg_count;
    } result_t;

    typedef struct packed {
        scan_mode_t         mode;
        logic               quote_is_double;
        logic               escape_pending;
        logic [COUNT_W-1:0] args_seen;
        status_t            error_code;
    } line_state_t;

    function automatic logic is_separator(input logic [CHAR_W-1:0] ch);
        is_separator = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
    endfunction

    function automatic logic [CHAR_W-1:0] unescape_char(input logic [CHAR_W-1:0] ch);
        case (ch)
            CH_LOW_N: unescape_char = CH_LF;
            CH_LOW_R: unescape_char = CH_CR;
            CH_LOW_T: unescape_char = CH_TAB;
            default:  unescape_char = ch;
        endcase
    endfunction

endpackage

### hdl/quoted_argument_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a command line, one character per word, into shell-style arguments
// with quoting and backslash escapes, and closes each line with a count and
// a status.
// ----------------------------------------------------------------------------
// Throughput is one character per clock cycle, sustained, with both sides
// streaming; a word accepted on s_ is held in the input register and its
// result reaches m_ from the result register. The figure is set by the line
// state update, which is a single registered loop: scan mode, quote kind,
// escape flag, argument count and error code are all updated together from
// one character. The argument limit is the APB register at byte address 0
// (reset 16); the user must write it only while the block is idle, and the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer
    import qat_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CHAR_W-1:0]  s_character,
    input  logic               s_end_of_line,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_out_char,
    output logic               m_char_valid,
    output logic               m_token_start,
    output logic               m_token_end,
    output logic               m_line_done,
    output logic [STAT_W-1:0]  m_status,
    output logic [COUNT_W-1:0] m_arg_count
);

    logic [COUNT_W-1:0] max_args;
    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               core_take;
    result_t            result;

    qat_apb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .max_args (max_args)
    );

    assign s_ready = !in_valid_reg || core_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= '{s_character, s_end_of_line};
        end
    end

    qat_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_args   (max_args),
        .in_valid   (in_valid_reg),
        .in_item    (in_item_reg),
        .in_take    (core_take),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (result)
    );

    assign m_out_char    = result.out_char;
    assign m_char_valid  = result.char_valid;
    assign m_token_start = result.token_start;
    assign m_token_end   = result.token_end;
    assign m_line_done   = result.line_done;
    assign m_status      = result.status;
    assign m_arg_count   = result.arg_count;

endmodule

### hdl/qat_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_apb_regs
// APB register file holding the per-line argument limit.
// ----------------------------------------------------------------------------
module qat_apb_regs
    import qat_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [COUNT_W-1:0] max_args
);

    logic [COUNT_W-1:0] max_args_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_ARGS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_args_reg <= MAX_ARGS_RESET;
        end else if (wr_en) begin
            max_args_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_MAX_ARGS: prdata = {{(DATA_W-COUNT_W){1'b0}}, max_args_reg};
            default:      prdata = '0;
        endcase
    end

    assign max_args = max_args_reg;

endmodule

### hdl/qat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_core
// Per-character scan logic with the line state registers and the result
// register. One word is processed per cycle when the result side can take it.
// ----------------------------------------------------------------------------
module qat_core
    import qat_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [COUNT_W-1:0] max_args,
    input  logic               in_valid,
    input  item_t              in_item,
    output logic               in_take,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_result
);

    line_state_t state_reg, state_next;
    result_t     result_reg, result_next;
    logic        out_valid_reg;

    assign in_take = in_valid && (!out_valid_reg || out_ready);

    always_comb begin
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              handle;
        logic [CHAR_W-1:0] quote_ch;
        ch          = in_item.character;
        last        = in_item.end_of_line;
        handle      = 1'b1;
        quote_ch    = state_reg.quote_is_double ? CH_DQUOTE : CH_SQUOTE;
        state_next  = state_reg;
        result_next = '0;

        if (state_reg.error_code == ST_OK) begin
            if (state_reg.escape_pending) begin
                state_next.escape_pending = 1'b0;
                result_next.out_char      = unescape_char(ch);
                result_next.char_valid    = 1'b1;
            end else begin
                if (state_reg.mode == MODE_GAP) begin
                    if (is_separator(ch)) begin
                        handle = 1'b0;
                    end else if (state_reg.args_seen >= max_args) begin
                        state_next.error_code = ST_TOO_MANY;
                        handle = 1'b0;
                    end else begin
                        state_next.args_seen   = state_reg.args_seen + 1'b1;
                        result_next.token_start = 1'b1;
                        state_next.mode        = MODE_TOKEN;
                    end
                end
                if (handle) begin
                    case (state_next.mode)
                        MODE_TOKEN: begin
                            if (is_separator(ch)) begin
                                result_next.token_end = 1'b1;
                                state_next.mode       = MODE_GAP;
                            end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
                                state_next.mode            = MODE_QUOTE;
                                state_next.quote_is_double = (ch == CH_DQUOTE);
                            end else if (ch == CH_BSLASH && !last) begin
                                state_next.escape_pending = 1'b1;
                            end else begin
                                result_next.out_char   = ch;
                                result_next.char_valid = 1'b1;
                            end
                        end
                        MODE_QUOTE: begin
                            if (ch == quote_ch) begin
                                state_next.mode = MODE_TOKEN;
                            end else if (ch == CH_BSLASH && !last) begin
                                state_next.escape_pending = 1'b1;
                            end else begin
                                result_next.out_char   = ch;
                                result_next.char_valid = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (last && state_next.error_code == ST_OK) begin
                if (state_next.mode == MODE_QUOTE) begin
                    state_next.error_code = ST_UNTERMINATED;
                end else if (state_next.mode == MODE_TOKEN) begin
                    result_next.token_end = 1'b1;
                end
            end
        end

        result_next.arg_count = state_next.args_seen;
        if (last) begin
            result_next.line_done = 1'b1;
            result_next.status    = state_next.error_code;
            state_next            = '{MODE_GAP, 1'b0, 1'b0, '0, ST_OK};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '{MODE_GAP, 1'b0, 1'b0, '0, ST_OK};
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                state_reg <= state_next;
            end
            if (in_take) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule
